// ----- rtl/fir_filter_edge_passthrough_unit_macros.svh -----
// assertion macros for the fir edge pass-through filter
// no dependencies; included by the top level only
`ifndef FIR_FILTER_EDGE_PASSTHROUGH_UNIT_MACROS_SVH
`define FIR_FILTER_EDGE_PASSTHROUGH_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication, disabled during reset
`define FEP_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("fep: same-cycle check failed");
// next-cycle implication, disabled during reset
`define FEP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("fep: next-cycle check failed");
`else
`define FEP_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define FEP_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

// ----- rtl/fep_pkg.sv -----
// shared constants and types for the fir edge pass-through filter
// no dependencies; used by every module of the block
package fep_pkg;

    localparam int MAX_TAPS   = 7;
    localparam int SAMPLE_W   = 8;
    localparam int COEF_W     = 16;
    localparam int TAP_W      = 3;
    localparam int IDX_W      = 3;
    localparam int HALF_W     = 2;
    localparam int SEEN_W     = 3;
    localparam int ADDR_W     = 5;
    localparam int DATA_W     = 32;
    localparam int FRAC_W     = 15;
    localparam int PROD_W     = COEF_W + SAMPLE_W + 1;
    localparam int ACC_W      = PROD_W + 3;

    // register indexes on the config port
    localparam logic [IDX_W-1:0] REG_TAP_COUNT = 3'd0;
    localparam logic [IDX_W-1:0] REG_COEF_0    = 3'd1;

    // reset values
    localparam logic [TAP_W-1:0]  TAP_COUNT_RST = 3'd3;
    localparam logic [COEF_W-1:0] COEF_MEAN_RST = 16'd10923;
    localparam int                MEAN_TAPS     = 3;

    typedef logic [MAX_TAPS-1:0][COEF_W-1:0] coef_arr_t;

    // live configuration seen by the datapath
    typedef struct packed {
        logic [TAP_W-1:0] tap_count;
        coef_arr_t        coef;
    } cfg_t;

    // controls for the shared multiply-accumulate unit
    typedef struct packed {
        logic clr;
        logic en;
    } mac_ctl_t;

endpackage

// ----- rtl/fep_cfg.sv -----
// apb register bank: tap count and seven q1.15 coefficients
// depends on fep_pkg
module fep_cfg (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [fep_pkg::ADDR_W-1:0]  paddr,
    input  logic [fep_pkg::DATA_W-1:0]  pwdata,
    output logic [fep_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output fep_pkg::cfg_t               cfg
);

    logic [fep_pkg::TAP_W-1:0] tap_count_reg;
    fep_pkg::coef_arr_t        coef_reg;
    logic [fep_pkg::IDX_W-1:0] reg_idx;
    logic [fep_pkg::IDX_W-1:0] coef_idx;
    logic                      wr_en;

    assign pready   = 1'b1;
    assign reg_idx  = paddr[fep_pkg::ADDR_W-1:2];
    assign coef_idx = reg_idx - fep_pkg::REG_COEF_0;
    assign wr_en    = psel && penable && pwrite;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tap_count_reg <= fep_pkg::TAP_COUNT_RST;
            for (int k = 0; k < fep_pkg::MAX_TAPS; k++) begin
                coef_reg[k] <= (k < fep_pkg::MEAN_TAPS) ? fep_pkg::COEF_MEAN_RST : '0;
            end
        end else if (wr_en) begin
            if (reg_idx == fep_pkg::REG_TAP_COUNT) begin
                tap_count_reg <= pwdata[fep_pkg::TAP_W-1:0];
            end else begin
                coef_reg[coef_idx] <= pwdata[fep_pkg::COEF_W-1:0];
            end
        end
    end

    // read-back
    always_comb begin
        if (reg_idx == fep_pkg::REG_TAP_COUNT) begin
            prdata = fep_pkg::DATA_W'(tap_count_reg);
        end else begin
            prdata = fep_pkg::DATA_W'(coef_reg[coef_idx]);
        end
    end

    assign cfg.tap_count = tap_count_reg;
    assign cfg.coef      = coef_reg;

endmodule

// ----- rtl/fep_mac.sv -----
// shared multiply-accumulate unit: one coefficient times one sample per cycle
// depends on fep_pkg; product registered before it is summed
module fep_mac (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  fep_pkg::mac_ctl_t                  ctl,
    input  logic signed [fep_pkg::COEF_W-1:0]  coef,
    input  logic [fep_pkg::SAMPLE_W-1:0]       smp,
    output logic signed [fep_pkg::ACC_W-1:0]   acc
);

    logic signed [fep_pkg::PROD_W-1:0] prod_reg;
    logic signed [fep_pkg::PROD_W-1:0] prod_next;
    logic                              prod_vld_reg;
    logic signed [fep_pkg::ACC_W-1:0]  acc_reg;
    logic signed [fep_pkg::ACC_W-1:0]  acc_next;

    function automatic logic signed [fep_pkg::PROD_W-1:0] PROD_W_MUL(
        input logic signed [fep_pkg::COEF_W-1:0] c,
        input logic [fep_pkg::SAMPLE_W-1:0]      s
    );
        logic signed [fep_pkg::SAMPLE_W:0] s_ext;
        s_ext      = $signed({1'b0, s});
        PROD_W_MUL = c * s_ext;
    endfunction

    // signed coefficient times zero-extended sample
    assign prod_next = PROD_W_MUL(coef, smp);

    // accumulate the previous cycle's product
    always_comb begin
        if (ctl.clr) begin
            acc_next = '0;
        end else if (prod_vld_reg) begin
            acc_next = acc_reg + fep_pkg::ACC_W'(prod_reg);
        end else begin
            acc_next = acc_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_vld_reg <= 1'b0;
            acc_reg      <= '0;
        end else begin
            prod_vld_reg <= ctl.en;
            acc_reg      <= acc_next;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

    assign acc = acc_reg;

endmodule

// ----- rtl/fir_filter_edge_passthrough_unit.sv -----
// channel   ports                               dir   request moves
// input     s_valid s_ready s_sample s_last_in  in    one audio sample
// result    m_valid m_ready m_filtered m_last_out out one output sample
// config    psel penable pwrite paddr pwdata..  in    one register write
//
// no-output samples stay in idle; pass-through uses pass and emit, filtering
// mac, drain, round and emit; the shared multiply-accumulate unit handles one
// tap per cycle. a final sample adds one flushed output per trailing edge
// sample (up to 3). a full output register stalls the sequencer until taken.
// reset is synchronous and clears window, count and config to defaults.
`include "fir_filter_edge_passthrough_unit_macros.svh"
// top level: window, sequencer, rounding and output register
// depends on fep_pkg, fep_cfg, fep_mac
module fir_filter_edge_passthrough_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [fep_pkg::SAMPLE_W-1:0]  s_sample,
    input  logic                          s_last_in,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [fep_pkg::SAMPLE_W-1:0]  m_filtered,
    output logic                          m_last_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fep_pkg::ADDR_W-1:0]    paddr,
    input  logic [fep_pkg::DATA_W-1:0]    pwdata,
    output logic [fep_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MAC   = 3'd1;
    localparam logic [2:0] ST_DRAIN = 3'd2;
    localparam logic [2:0] ST_ROUND = 3'd3;
    localparam logic [2:0] ST_PASS  = 3'd4;
    localparam logic [2:0] ST_EMIT  = 3'd5;
    localparam logic [2:0] ST_FLUSH = 3'd6;

    localparam logic [fep_pkg::SEEN_W-1:0] SEEN_MAX = '1;
    localparam logic [fep_pkg::SAMPLE_W-1:0] SAMPLE_MAX = '1;
    localparam int SH_W = fep_pkg::ACC_W - fep_pkg::FRAC_W;

    typedef logic [fep_pkg::MAX_TAPS-1:0][fep_pkg::SAMPLE_W-1:0] win_t;

    fep_pkg::cfg_t     cfg;
    fep_pkg::mac_ctl_t mac_ctl;
    logic signed [fep_pkg::ACC_W-1:0] acc;

    logic [2:0]                    state_reg, state_next;
    win_t                          win_reg, win_next;
    logic [fep_pkg::SEEN_W-1:0]    seen_reg, seen_next;
    logic [fep_pkg::HALF_W-1:0]    half_reg, half_next;
    logic                          last_reg, last_next;
    logic [fep_pkg::HALF_W-1:0]    flush_reg, flush_next;
    logic [fep_pkg::IDX_W-1:0]     k_reg, k_next;
    logic [fep_pkg::SAMPLE_W-1:0]  res_reg, res_next;
    logic                          m_valid_reg, m_valid_next;
    logic [fep_pkg::SAMPLE_W-1:0]  m_filtered_reg, m_filtered_next;
    logic                          m_last_reg, m_last_next;

    logic [fep_pkg::TAP_W-1:0]     taps_eff;
    logic [fep_pkg::HALF_W-1:0]    half_cfg;
    logic [fep_pkg::SEEN_W-1:0]    seen_inc;
    logic [fep_pkg::IDX_W-1:0]     rd_idx;
    logic [fep_pkg::SAMPLE_W-1:0]  win_rd;
    logic                          out_free;
    logic                          s_accept;
    logic signed [fep_pkg::ACC_W-1:0] rnd;
    logic [SH_W-1:0]               rnd_sh;
    logic [fep_pkg::SAMPLE_W-1:0]  sat_val;

    fep_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    fep_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (mac_ctl),
        .coef    ($signed(cfg.coef[k_reg])),
        .smp     (win_rd),
        .acc     (acc)
    );

    // effective tap count is always odd; half width of the window
    assign taps_eff = cfg.tap_count | fep_pkg::TAP_W'(1);
    assign half_cfg = taps_eff[fep_pkg::TAP_W-1:1];
    assign seen_inc = (seen_reg == SEEN_MAX) ? seen_reg : seen_reg + 1'b1;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // single window read port, address picked by the sequencer
    always_comb begin
        case (state_reg)
            ST_MAC:   rd_idx = k_reg;
            ST_FLUSH: rd_idx = fep_pkg::IDX_W'(flush_reg - 1'b1);
            default:  rd_idx = fep_pkg::IDX_W'(half_reg);
        endcase
    end
    assign win_rd = win_reg[rd_idx];

    // round half up from q1.15, clamp to sample range
    assign rnd    = acc + fep_pkg::ACC_W'(1 << (fep_pkg::FRAC_W - 1));
    assign rnd_sh = rnd[fep_pkg::ACC_W-1:fep_pkg::FRAC_W];
    always_comb begin
        if (rnd[fep_pkg::ACC_W-1]) begin
            sat_val = '0;
        end else if (rnd_sh > SH_W'(SAMPLE_MAX)) begin
            sat_val = SAMPLE_MAX;
        end else begin
            sat_val = rnd_sh[fep_pkg::SAMPLE_W-1:0];
        end
    end

    // sequencer
    always_comb begin
        state_next      = state_reg;
        win_next        = win_reg;
        seen_next       = seen_reg;
        half_next       = half_reg;
        last_next       = last_reg;
        flush_next      = flush_reg;
        k_next          = k_reg;
        res_next        = res_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_filtered_next = m_filtered_reg;
        m_last_next     = m_last_reg;
        mac_ctl.clr     = 1'b0;
        mac_ctl.en      = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    win_next    = {win_reg[fep_pkg::MAX_TAPS-2:0], s_sample};
                    seen_next   = seen_inc;
                    half_next   = half_cfg;
                    last_next   = s_last_in;
                    k_next      = '0;
                    mac_ctl.clr = 1'b1;
                    if (!s_last_in) begin
                        flush_next = '0;
                    end else if (seen_inc > fep_pkg::SEEN_W'(half_cfg)) begin
                        flush_next = half_cfg;
                    end else begin
                        flush_next = seen_inc[fep_pkg::HALF_W-1:0];
                    end
                    if (seen_inc > fep_pkg::SEEN_W'(half_cfg)) begin
                        if (seen_inc <= fep_pkg::SEEN_W'({half_cfg, 1'b0})) begin
                            state_next = ST_PASS;
                        end else begin
                            state_next = ST_MAC;
                        end
                    end else if (s_last_in) begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_MAC: begin
                mac_ctl.en = 1'b1;
                k_next     = k_reg + 1'b1;
                if (k_reg == fep_pkg::IDX_W'({half_reg, 1'b0})) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_ROUND;
            end
            ST_ROUND: begin
                res_next   = sat_val;
                state_next = ST_EMIT;
            end
            ST_PASS: begin
                res_next   = win_rd;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next    = 1'b1;
                    m_filtered_next = res_reg;
                    m_last_next     = last_reg && (flush_reg == '0);
                    if (flush_reg != '0) begin
                        state_next = ST_FLUSH;
                    end else begin
                        state_next = ST_IDLE;
                        if (last_reg) begin
                            win_next  = '0;
                            seen_next = '0;
                            last_next = 1'b0;
                        end
                    end
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    m_valid_next    = 1'b1;
                    m_filtered_next = win_rd;
                    m_last_next     = (flush_reg == fep_pkg::HALF_W'(1));
                    flush_next      = flush_reg - 1'b1;
                    if (flush_reg == fep_pkg::HALF_W'(1)) begin
                        state_next = ST_IDLE;
                        win_next   = '0;
                        seen_next  = '0;
                        last_next  = 1'b0;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            win_reg     <= '0;
            seen_reg    <= '0;
            last_reg    <= 1'b0;
            flush_reg   <= '0;
            k_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            win_reg     <= win_next;
            seen_reg    <= seen_next;
            last_reg    <= last_next;
            flush_reg   <= flush_next;
            k_reg       <= k_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        half_reg       <= half_next;
        res_reg        <= res_next;
        m_filtered_reg <= m_filtered_next;
        m_last_reg     <= m_last_next;
    end

    assign m_valid    = m_valid_reg;
    assign m_filtered = m_filtered_reg;
    assign m_last_out = m_last_reg;

    // checks
    `FEP_ASSERT_IMPL(a_empty_window, aclk, aresetn, seen_reg == '0, win_reg == '0)
    `FEP_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_filtered) && $stable(m_last_out))
    `FEP_ASSERT_IMPL(a_flush_only_last, aclk, aresetn, state_reg == ST_FLUSH, last_reg && (flush_reg != '0))
    `FEP_ASSERT_IMPL(a_tap_in_range, aclk, aresetn, state_reg == ST_MAC, k_reg <= fep_pkg::IDX_W'({half_reg, 1'b0}))

endmodule

// ----- dv/fir_filter_edge_passthrough_unit_tb.sv -----
// self-checking testbench for the fir edge pass-through filter: directed and random sample
// streams, an in-order predictor of every output value, and apb writes of taps and coefficients
// depends on fep_pkg and fir_filter_edge_passthrough_unit
module fir_filter_edge_passthrough_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES  = 400000;
    localparam int SETTLE_CYCLES = 24;
    localparam int PHASE_ITEMS   = 100;

    typedef struct packed {
        logic [fep_pkg::SAMPLE_W-1:0] filtered;
        logic                         last_out;
    } out_sample_t;

    logic                          aclk;
    logic                          aresetn;
    logic                          s_valid;
    logic                          s_ready;
    logic [fep_pkg::SAMPLE_W-1:0]  s_sample;
    logic                          s_last_in;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic [fep_pkg::SAMPLE_W-1:0]  m_filtered;
    logic                          m_last_out;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [fep_pkg::ADDR_W-1:0]    paddr;
    logic [fep_pkg::DATA_W-1:0]    pwdata;
    logic [fep_pkg::DATA_W-1:0]    prdata;
    logic                          pready;

    // predictor copy of configuration and filter state
    logic [fep_pkg::TAP_W-1:0]          tap_cfg;
    logic signed [fep_pkg::COEF_W-1:0]  coef_cfg [fep_pkg::MAX_TAPS];
    logic [fep_pkg::SAMPLE_W-1:0]       hist [fep_pkg::MAX_TAPS];
    logic [fep_pkg::SEEN_W-1:0]         seen_in_signal;
    out_sample_t                        expected_samples [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int items_sent      = 0;
    int results_checked = 0;
    int reg_writes      = 0;
    int mismatches      = 0;
    int cycles          = 0;

    fir_filter_edge_passthrough_unit dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_sample   (s_sample),
        .s_last_in  (s_last_in),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_filtered (m_filtered),
        .m_last_out (m_last_out),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // 2 ns clock
    always begin
        aclk = 1'b1;
        #1;
        aclk = 1'b0;
        #1;
    end

    // run limit
    always @(posedge aclk) begin
        cycles++;
        if (cycles >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d outputs still owed", cycles,
                     expected_samples.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // random receiver stalls
    always @(negedge aclk) begin
        m_ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic log_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch at cycle %0d: %s", cycles, msg);
    endtask

    // compare every output request against the oldest prediction
    always @(posedge aclk) begin
        out_sample_t want;
        if (aresetn && m_valid && m_ready) begin
            results_checked++;
            if (expected_samples.size() == 0) begin
                log_mismatch($sformatf("unexpected output filtered=%0d last_out=%0b",
                                       m_filtered, m_last_out));
            end else begin
                want = expected_samples.pop_front();
                if (m_filtered !== want.filtered)
                    log_mismatch($sformatf("filtered expected %0d got %0d",
                                           want.filtered, m_filtered));
                if (m_last_out !== want.last_out)
                    log_mismatch($sformatf("last_out expected %0b got %0b",
                                           want.last_out, m_last_out));
            end
        end
    end

    // rounded, saturated dot product of the window with the coefficients
    function automatic logic [fep_pkg::SAMPLE_W-1:0] fir_sum(input int taps);
        longint acc;
        int     k;
        acc = 0;
        for (k = 0; k < taps; k++)
            acc += longint'(coef_cfg[k]) * longint'(hist[k]);
        acc += longint'(1) << (fep_pkg::FRAC_W - 1);
        if (acc < 0)
            return '0;
        acc = acc >>> fep_pkg::FRAC_W;
        if (acc > (1 << fep_pkg::SAMPLE_W) - 1)
            return '1;
        return fep_pkg::SAMPLE_W'(acc);
    endfunction

    // advance the predictor by one accepted sample and queue the outputs it owes
    function automatic void predict_step(input logic [fep_pkg::SAMPLE_W-1:0] smp,
                                         input logic lst);
        int          taps;
        int          half;
        int          n;
        int          flush;
        int          k;
        out_sample_t step_out [$];
        out_sample_t r;
        taps = int'(tap_cfg | 3'd1);
        if (taps > fep_pkg::MAX_TAPS)
            taps = fep_pkg::MAX_TAPS;
        if ((taps & 1) == 0)
            taps -= 1;
        half = taps / 2;
        for (k = fep_pkg::MAX_TAPS - 1; k > 0; k--)
            hist[k] = hist[k - 1];
        hist[0] = smp;
        if (seen_in_signal < 7)
            seen_in_signal++;
        n = int'(seen_in_signal);
        // centered output, passed through near the start of the signal
        if (n >= half + 1) begin
            r.filtered = (n <= 2 * half) ? hist[half] : fir_sum(taps);
            r.last_out = 1'b0;
            step_out.push_back(r);
        end
        // end of signal flushes the trailing edge samples
        if (lst) begin
            flush = (half < n) ? half : n;
            for (k = flush - 1; k >= 0; k--) begin
                r.filtered = hist[k];
                r.last_out = 1'b0;
                step_out.push_back(r);
            end
            if (step_out.size() > 0)
                step_out[step_out.size() - 1].last_out = 1'b1;
            for (k = 0; k < fep_pkg::MAX_TAPS; k++)
                hist[k] = '0;
            seen_in_signal = '0;
        end
        foreach (step_out[i])
            expected_samples.push_back(step_out[i]);
    endfunction

    // one sample request; entered and left at a falling edge
    task automatic push_sample(input logic [fep_pkg::SAMPLE_W-1:0] smp, input logic lst);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid   <= 1'b0;
            s_sample  <= fep_pkg::SAMPLE_W'($urandom);
            s_last_in <= 1'($urandom);
            @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_sample  <= smp;
        s_last_in <= lst;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        predict_step(smp, lst);
        items_sent++;
        @(negedge aclk);
    endtask

    // apb write with setup and access cycles
    task automatic write_reg(input logic [fep_pkg::IDX_W-1:0] idx,
                             input logic [fep_pkg::DATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= fep_pkg::ADDR_W'({idx, 2'b00});
        pwdata  <= val;
        @(negedge aclk);
        penable <= 1'b1;
        do begin
            @(posedge aclk);
        end while (!pready);
        if (idx == fep_pkg::REG_TAP_COUNT)
            tap_cfg = val[fep_pkg::TAP_W-1:0];
        else
            coef_cfg[idx - fep_pkg::REG_COEF_0] = val[fep_pkg::COEF_W-1:0];
        reg_writes++;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
    endtask

    // all coefficients then the tap count, unused upper data bits randomized
    task automatic apply_config(input logic [fep_pkg::TAP_W-1:0] taps,
                                input fep_pkg::coef_arr_t c);
        int k;
        for (k = 0; k < fep_pkg::MAX_TAPS; k++)
            write_reg(fep_pkg::IDX_W'(fep_pkg::REG_COEF_0 + k), {16'($urandom), c[k]});
        write_reg(fep_pkg::REG_TAP_COUNT, {29'($urandom), taps});
    endtask

    // stop sending and wait until every owed output is taken and the block settles
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_samples.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    function automatic logic [fep_pkg::SAMPLE_W-1:0] pick_sample();
        int roll;
        roll = $urandom_range(99);
        if (roll < 8)
            return '0;
        if (roll < 16)
            return '1;
        return fep_pkg::SAMPLE_W'($urandom);
    endfunction

    // coefficient sets: raw random, extremes, or a unity-gain smoother with jitter
    function automatic fep_pkg::coef_arr_t random_coefs(input logic [fep_pkg::TAP_W-1:0] taps);
        fep_pkg::coef_arr_t c;
        int                 n;
        int                 mode;
        int                 k;
        n = int'(taps | 3'd1);
        mode = $urandom_range(0, 3);
        for (k = 0; k < fep_pkg::MAX_TAPS; k++) begin
            case (mode)
                0: begin
                    c[k] = fep_pkg::COEF_W'($urandom);
                end
                1: begin
                    case ($urandom_range(0, 3))
                        0: c[k] = 16'h8000;
                        1: c[k] = 16'h7fff;
                        2: c[k] = 16'h0000;
                        default: c[k] = 16'hffff;
                    endcase
                end
                default: begin
                    c[k] = fep_pkg::COEF_W'(32768 / n + int'($urandom_range(0, 1024)) - 512);
                end
            endcase
        end
        return c;
    endfunction

    // reset coefficients give a three-point mean
    task automatic test_reset_defaults();
        push_sample(8'd0, 1'b0);
        push_sample(8'd255, 1'b0);
        push_sample(8'd255, 1'b0);
        push_sample(8'd128, 1'b0);
        push_sample(8'd7, 1'b1);
        wait_drained();
    endtask

    // saturation at both ends and round-half-up
    task automatic test_saturation_rounding();
        fep_pkg::coef_arr_t c;
        c = {fep_pkg::MAX_TAPS{16'h7fff}};
        apply_config(3'd3, c);
        push_sample(8'd255, 1'b0);
        push_sample(8'd255, 1'b0);
        push_sample(8'd255, 1'b1);
        wait_drained();
        c = {fep_pkg::MAX_TAPS{16'h8000}};
        apply_config(3'd3, c);
        push_sample(8'd255, 1'b0);
        push_sample(8'd200, 1'b0);
        push_sample(8'd255, 1'b1);
        wait_drained();
        // zero taps act as one tap of one half
        c = '0;
        c[0] = 16'h4000;
        apply_config(3'd0, c);
        push_sample(8'd1, 1'b0);
        push_sample(8'd3, 1'b0);
        push_sample(8'd254, 1'b1);
        wait_drained();
    endtask

    // even tap counts round up, short signals pass through whole
    task automatic test_short_signal_even_taps();
        apply_config(3'd6, random_coefs(3'd6));
        push_sample(pick_sample(), 1'b0);
        push_sample(8'd255, 1'b0);
        push_sample(8'd0, 1'b0);
        push_sample(pick_sample(), 1'b1);
        wait_drained();
        apply_config(3'd4, random_coefs(3'd4));
        push_sample(8'd99, 1'b1);
        wait_drained();
    endtask

    // tap count shrinks in the middle of a signal
    task automatic test_tap_change_mid_signal();
        int i;
        apply_config(3'd7, random_coefs(3'd7));
        for (i = 0; i < 4; i++)
            push_sample(pick_sample(), 1'b0);
        wait_drained();
        write_reg(fep_pkg::REG_TAP_COUNT, fep_pkg::DATA_W'(2));
        for (i = 0; i < 3; i++)
            push_sample(pick_sample(), i == 2);
        wait_drained();
    endtask

    // random signals of mixed length under one flow-control pattern
    task automatic test_random_traffic(input logic [fep_pkg::TAP_W-1:0] first_taps,
                                       input int idle_pct, input int stall_pct);
        int                        phase_items;
        int                        len;
        int                        i;
        logic [fep_pkg::TAP_W-1:0] t;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        apply_config(first_taps, random_coefs(first_taps));
        phase_items = 0;
        while (phase_items < PHASE_ITEMS) begin
            if ($urandom_range(99) < 25) begin
                wait_drained();
                t = fep_pkg::TAP_W'($urandom);
                apply_config(t, random_coefs(t));
            end
            len = ($urandom_range(99) < 80) ? $urandom_range(1, 16) : $urandom_range(17, 60);
            for (i = 0; i < len; i++) begin
                // occasional tap change inside a signal
                if (i > 0 && i == len / 2 && $urandom_range(99) < 8) begin
                    wait_drained();
                    write_reg(fep_pkg::REG_TAP_COUNT, {29'($urandom), 3'($urandom)});
                end
                push_sample(pick_sample(), i == len - 1);
            end
            phase_items += len;
        end
        wait_drained();
    endtask

    initial begin
        int k;
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_sample  = '0;
        s_last_in = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        tap_cfg   = fep_pkg::TAP_COUNT_RST;
        for (k = 0; k < fep_pkg::MAX_TAPS; k++) begin
            coef_cfg[k] = (k < fep_pkg::MEAN_TAPS) ? fep_pkg::COEF_MEAN_RST : '0;
            hist[k]     = '0;
        end
        seen_in_signal = '0;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        repeat (4) @(negedge aclk);

        test_reset_defaults();
        test_saturation_rounding();
        test_short_signal_even_taps();
        test_tap_change_mid_signal();
        test_random_traffic(3'd7, 0, 0);
        test_random_traffic(3'd1, 53, 0);
        test_random_traffic(3'd5, 0, 53);
        test_random_traffic(3'd0, 13, 13);

        $display("sent %0d samples, checked %0d outputs, %0d register writes", items_sent,
                 results_checked, reg_writes);
        $display("tap counts 0..7, extreme and smoothing coefficients, four flow patterns");
        if (mismatches == 0 && expected_samples.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches, %0d outputs never seen", mismatches,
                     expected_samples.size());
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
